[sv/ohm_pkg.sv]
// Shared types, constants and helper functions for the open-address hash map.
package ohm_pkg;

  localparam int SLOT_W = 10;
  localparam int CNT_W  = 11;
  localparam int LOG_W  = 4;
  localparam int CFG_W  = 11;
  localparam int HASH_W = 32;
  localparam int VAL_W  = 32;
  localparam int KEY_W  = 32;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PRD,
    ST_PCHK,
    ST_GSWEEP,
    ST_GRD,
    ST_GCHK,
    ST_GPRD,
    ST_GPCHK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              free;
    logic              match;
    logic              last;
    logic [SLOT_W-1:0] next_z;
  } probe_res_t;

  function automatic logic [SLOT_W-1:0] mask_of(input logic [LOG_W-1:0] lg);
    logic [SLOT_W:0] sz;
    sz = (SLOT_W+1)'(1) << lg;
    return SLOT_W'(sz - (SLOT_W+1)'(1));
  endfunction

  function automatic int largest_log(input int max_entries);
    int l;
    l = 0;
    for (int i = 0; i < SLOT_W; i++) begin
      if ((2 << l) <= max_entries) l++;
    end
    return l;
  endfunction

  function automatic logic [LOG_W-1:0] init_log(input logic [CFG_W-1:0] req,
                                                 input int min_slots, input int cap);
    int l;
    logic [CFG_W:0] sz;
    l = 0;
    for (int i = 0; i < SLOT_W; i++) begin
      sz = (CFG_W+1)'(1) << l;
      if (l < cap && (int'(sz) < min_slots || sz < {1'b0, req})) l++;
    end
    return LOG_W'(l);
  endfunction

endpackage

[sv/ohm_in_if.sv]
// Request channel carrying one table operation.
interface ohm_in_if import ohm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [KEY_W-1:0]  key;
  logic [HASH_W-1:0] key_hash;
  logic [VAL_W-1:0]  new_value;

  modport source (output valid, op, key, key_hash, new_value, input ready);
  modport sink   (input valid, op, key, key_hash, new_value, output ready);
endinterface

[sv/ohm_out_if.sv]
// Result channel carrying the answer to one operation.
interface ohm_out_if import ohm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [VAL_W-1:0]  value_out;
  logic [SLOT_W-1:0] slot;
  logic              status;
  logic [CNT_W-1:0]  entry_total;

  modport source (output valid, found, value_out, slot, status, entry_total, input ready);
  modport sink   (input valid, found, value_out, slot, status, entry_total, output ready);
endinterface

[sv/ohm_cfg_if.sv]
// Configuration write channel for the starting capacity register.
interface ohm_cfg_if import ohm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] start_capacity;

  modport source (output valid, start_capacity, input ready);
  modport sink   (input valid, start_capacity, output ready);
endinterface

[sv/ohm_mem.sv]
// Single write port, single registered read port slot memory.
module ohm_mem import ohm_pkg::*; #(
  parameter int WIDTH = 97,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/ohm_probe_unit.sv]
// Shared probe step: slot test against the key and the next probe position.
module ohm_probe_unit import ohm_pkg::*; #(
  parameter int KW            = 32,
  parameter int PROBE_ADVANCE = 0
) (
  input  logic [LOG_W-1:0]  lg,
  input  logic [SLOT_W-1:0] z,
  input  logic [CNT_W-1:0]  n,
  input  logic              used,
  input  logic [KW-1:0]     stored_key,
  input  logic [KW-1:0]     key,
  output probe_res_t        res
);

  localparam logic [SLOT_W:0] STEP = (SLOT_W+1)'(PROBE_ADVANCE + 1);

  logic [SLOT_W:0] sum;
  logic [CNT_W-1:0] size;

  always_comb begin
    sum        = {1'b0, z} + STEP;
    size       = CNT_W'(1) << lg;
    res.free   = !used;
    res.match  = used && (stored_key == key);
    res.last   = (n + CNT_W'(1)) == size;
    res.next_z = sum[SLOT_W-1:0] & mask_of(lg);
  end

endmodule

[sv/open_address_hash_map.sv]
// Top level of the open-address hash map with doubling growth.
// A request is a put, a get, a clear or a no-op; one result comes back per request. The block
// handles one request at a time: a get or put reads each probed slot on the single memory
// read port and then checks it before the reply is offered. A put that pushes occupancy
// above half doubles the capacity unless it is at its limit: the target bank is swept,
// then every old slot is read and rehashed into it.
// A clear, and reset, sweep bank 0 before the next request.
module open_address_hash_map import ohm_pkg::*; #(
  parameter int MAX_ENTRIES   = 1024,
  parameter int PROBE_ADVANCE = 0,
  parameter int MIN_SLOTS     = 4,
  parameter int KEY_BITS      = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ohm_in_if.sink    in_ch,
  ohm_out_if.source out_ch,
  ohm_cfg_if.sink   cfg_ch
);

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int LARGEST_LOG = largest_log(MAX_ENTRIES);
  localparam logic [LOG_W-1:0] MAX_LOG = LOG_W'(LARGEST_LOG);
  localparam logic [LOG_W-1:0] RESET_LOG = init_log(CFG_W'(8), MIN_SLOTS, LARGEST_LOG);
  localparam int AW = SLOT_W + 1;
  localparam int WW = 1 + KW + HASH_W + VAL_W;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] sweep_r, sweep_nxt;
  logic              clr_reply_r, clr_reply_nxt;
  op_t               op_r, op_nxt;
  logic [KW-1:0]     key_r, key_nxt;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [SLOT_W-1:0] z_r, z_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [SLOT_W-1:0] src_r, src_nxt;
  logic [SLOT_W-1:0] track_r, track_nxt;
  logic [SLOT_W-1:0] gres_r, gres_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LOG_W-1:0]  cap_log_r, cap_log_nxt;
  logic              bank_r, bank_nxt;
  logic [CFG_W-1:0]  start_cap_r;
  logic [KW-1:0]     ent_key_r, ent_key_nxt;
  logic [HASH_W-1:0] ent_hash_r, ent_hash_nxt;
  logic [VAL_W-1:0]  ent_val_r, ent_val_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              found_r, found_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              status_r, status_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WW-1:0]     mem_wdata, mem_rdata;
  logic              rd_used;
  logic [KW-1:0]     rd_key;
  logic [HASH_W-1:0] rd_hash;
  logic [VAL_W-1:0]  rd_val;

  logic              growing;
  logic [LOG_W-1:0]  pr_log;
  logic [KW-1:0]     pr_key;
  probe_res_t        pr;
  logic [CNT_W:0]    twice_count;
  logic [CNT_W:0]    size_now;

  assign {rd_used, rd_key, rd_hash, rd_val} = mem_rdata;

  ohm_mem #(.WIDTH(WW), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign growing = (state_r == ST_GPCHK);
  assign pr_log  = growing ? cap_log_r + LOG_W'(1) : cap_log_r;
  assign pr_key  = growing ? ent_key_r : key_r;

  ohm_probe_unit #(.KW(KW), .PROBE_ADVANCE(PROBE_ADVANCE)) u_probe (
    .lg         (pr_log),
    .z          (z_r),
    .n          (n_r),
    .used       (rd_used),
    .stored_key (rd_key),
    .key        (pr_key),
    .res        (pr)
  );

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = found_r;
  assign out_ch.value_out  = value_r;
  assign out_ch.slot       = slot_r;
  assign out_ch.status     = status_r;
  assign out_ch.entry_total = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_r     <= '0;
      clr_reply_r <= 1'b0;
      count_r     <= '0;
      cap_log_r   <= RESET_LOG;
      bank_r      <= 1'b0;
      start_cap_r <= CFG_W'(8);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      clr_reply_r <= clr_reply_nxt;
      count_r     <= count_nxt;
      cap_log_r   <= cap_log_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) start_cap_r <= cfg_ch.start_capacity;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    hash_r     <= hash_nxt;
    val_r      <= val_nxt;
    z_r        <= z_nxt;
    n_r        <= n_nxt;
    src_r      <= src_nxt;
    track_r    <= track_nxt;
    gres_r     <= gres_nxt;
    ent_key_r  <= ent_key_nxt;
    ent_hash_r <= ent_hash_nxt;
    ent_val_r  <= ent_val_nxt;
    found_r    <= found_nxt;
    value_r    <= value_nxt;
    slot_r     <= slot_nxt;
    status_r   <= status_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    clr_reply_nxt = clr_reply_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    hash_nxt      = hash_r;
    val_nxt       = val_r;
    z_nxt         = z_r;
    n_nxt         = n_r;
    src_nxt       = src_r;
    track_nxt     = track_r;
    gres_nxt      = gres_r;
    count_nxt     = count_r;
    cap_log_nxt   = cap_log_r;
    bank_nxt      = bank_r;
    ent_key_nxt   = ent_key_r;
    ent_hash_nxt  = ent_hash_r;
    ent_val_nxt   = ent_val_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    value_nxt     = value_r;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    mem_we        = 1'b0;
    mem_waddr     = {bank_r, z_r};
    mem_wdata     = {1'b1, key_r, hash_r, val_r};
    mem_raddr     = {bank_r, z_r};
    twice_count   = {count_r + CNT_W'(1), 1'b0};
    size_now      = (CNT_W+1)'(1) << cap_log_r;

    unique case (state_r)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b0, sweep_r};
        mem_wdata = '0;
        sweep_nxt = sweep_r + SLOT_W'(1);
        if (sweep_r == '1) begin
          if (clr_reply_r) begin
            state_nxt     = ST_OUT;
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = op_t'(in_ch.op);
          key_nxt    = in_ch.key[KW-1:0];
          hash_nxt   = in_ch.key_hash;
          val_nxt    = in_ch.new_value;
          z_nxt      = in_ch.key_hash[SLOT_W-1:0] & mask_of(cap_log_r);
          n_nxt      = '0;
          found_nxt  = 1'b0;
          value_nxt  = '0;
          slot_nxt   = '0;
          status_nxt = 1'b0;
          unique case (op_t'(in_ch.op))
            OP_PUT, OP_GET: state_nxt = ST_PRD;
            OP_CLEAR: begin
              count_nxt     = '0;
              bank_nxt      = 1'b0;
              cap_log_nxt   = init_log(start_cap_r, MIN_SLOTS, LARGEST_LOG);
              sweep_nxt     = '0;
              clr_reply_nxt = 1'b1;
              state_nxt     = ST_SWEEP;
            end
            OP_NONE: begin
              state_nxt     = ST_OUT;
              out_valid_nxt = 1'b1;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PRD: begin
        mem_raddr = {bank_r, z_r};
        state_nxt = ST_PCHK;
      end
      ST_PCHK: begin
        priority if (pr.free || pr.match) begin
          slot_nxt = z_r;
          if (op_r == OP_GET) begin
            found_nxt     = pr.match;
            value_nxt     = pr.match ? rd_val : '0;
            state_nxt     = ST_OUT;
            out_valid_nxt = 1'b1;
          end else begin
            // An update keeps the hash that was stored with the entry.
            mem_we    = 1'b1;
            mem_waddr = {bank_r, z_r};
            mem_wdata = {1'b1, key_r, pr.match ? rd_hash : hash_r, val_r};
            found_nxt = pr.match;
            if (pr.match || !(twice_count > size_now && cap_log_r < MAX_LOG)) begin
              if (pr.free) count_nxt = count_r + CNT_W'(1);
              state_nxt     = ST_OUT;
              out_valid_nxt = 1'b1;
            end else begin
              // Occupancy passed one half: sweep the other bank and rehash into it.
              count_nxt = count_r + CNT_W'(1);
              track_nxt = z_r;
              gres_nxt  = '0;
              sweep_nxt = '0;
              state_nxt = ST_GSWEEP;
            end
          end
        end else if (pr.last) begin
          slot_nxt      = hash_r[SLOT_W-1:0] & mask_of(cap_log_r);
          status_nxt    = (op_r == OP_PUT);
          state_nxt     = ST_OUT;
          out_valid_nxt = 1'b1;
        end else begin
          z_nxt     = pr.next_z;
          n_nxt     = n_r + CNT_W'(1);
          state_nxt = ST_PRD;
        end
      end
      ST_GSWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = {~bank_r, sweep_r};
        mem_wdata = '0;
        sweep_nxt = sweep_r + SLOT_W'(1);
        if (sweep_r == '1) begin
          src_nxt   = '0;
          state_nxt = ST_GRD;
        end
      end
      ST_GRD: begin
        mem_raddr = {bank_r, src_r};
        state_nxt = ST_GCHK;
      end
      ST_GCHK: begin
        if (rd_used) begin
          ent_key_nxt  = rd_key;
          ent_hash_nxt = rd_hash;
          ent_val_nxt  = rd_val;
          z_nxt        = rd_hash[SLOT_W-1:0] & mask_of(cap_log_r + LOG_W'(1));
          n_nxt        = '0;
          state_nxt    = ST_GPRD;
        end else if (src_r == mask_of(cap_log_r)) begin
          bank_nxt      = ~bank_r;
          cap_log_nxt   = cap_log_r + LOG_W'(1);
          slot_nxt      = gres_r;
          state_nxt     = ST_OUT;
          out_valid_nxt = 1'b1;
        end else begin
          src_nxt   = src_r + SLOT_W'(1);
          state_nxt = ST_GRD;
        end
      end
      ST_GPRD: begin
        mem_raddr = {~bank_r, z_r};
        state_nxt = ST_GPCHK;
      end
      ST_GPCHK: begin
        if (pr.free || pr.match || pr.last) begin
          if (pr.free || pr.match) begin
            mem_we    = 1'b1;
            mem_waddr = {~bank_r, z_r};
            mem_wdata = {1'b1, ent_key_r, ent_hash_r, ent_val_r};
            if (src_r == track_r) gres_nxt = z_r;
          end
          if (src_r == mask_of(cap_log_r)) begin
            bank_nxt      = ~bank_r;
            cap_log_nxt   = cap_log_r + LOG_W'(1);
            slot_nxt      = (pr.free || pr.match) && src_r == track_r ? z_r : gres_r;
            state_nxt     = ST_OUT;
            out_valid_nxt = 1'b1;
          end else begin
            src_nxt   = src_r + SLOT_W'(1);
            state_nxt = ST_GRD;
          end
        end else begin
          z_nxt     = pr.next_z;
          n_nxt     = n_r + CNT_W'(1);
          state_nxt = ST_GPRD;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          clr_reply_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid_r && in_ch.ready))
    else $error("result pending while accepting a new request");

  a_count_fits: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} <= ((CNT_W+1)'(1) << cap_log_r))
    else $error("entry count exceeds capacity");

  a_log_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cap_log_r <= MAX_LOG)
    else $error("capacity grew past its limit");

  a_full_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r |-> !found_r && value_r == '0)
    else $error("refused put reports a found key or value");

  a_grow_swaps_bank: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE && cap_log_nxt != cap_log_r && state_nxt == ST_OUT
      |=> $past(bank_r) != bank_r)
    else $error("growth finished without switching bank");

endmodule

[dv/open_address_hash_map_tb.sv]
// Testbench for the open-address hash map: directed table, then random traffic checked by a predictor.
module open_address_hash_map_tb;
  import ohm_pkg::*;

  localparam int LARGEST_LOG = 10;
  localparam int WATCHDOG    = 4000000;

  typedef struct packed {
    logic              found;
    logic [VAL_W-1:0]  value_out;
    logic [SLOT_W-1:0] slot;
    logic              status;
    logic [CNT_W-1:0]  entry_total;
  } answer_t;

  typedef struct {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [31:0]      key_hash;
    logic [31:0]      new_value;
    bit               typed;
    answer_t          want;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  always #2 clk = ~clk;

  ohm_in_if  in_ch();
  ohm_out_if out_ch();
  ohm_cfg_if cfg_ch();

  open_address_hash_map dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                             .cfg_ch(cfg_ch));

  // Predictor state.
  logic [31:0] tbl_key [2048];
  logic [31:0] tbl_hash[2048];
  logic [31:0] tbl_val [2048];
  bit          tbl_used[2048];
  int unsigned n_entries, cap_log, bank, req_cap;

  answer_t answer_q[$];
  int  errors = 0;
  bit  hold_out = 0;
  int  idle_cycles = 0;
  bit  big_stall_req = 0;

  function automatic int unsigned start_log();
    int unsigned l = 0;
    while (l < LARGEST_LOG && ((1 << l) < 4 || (1 << l) < req_cap)) l++;
    return l;
  endfunction

  function automatic void table_clear();
    foreach (tbl_used[i]) tbl_used[i] = 0;
    n_entries = 0;
    bank = 0;
    cap_log = start_log();
  endfunction

  // 0 free slot, 1 key hit, 2 exhausted.
  function automatic int probe_slot(int unsigned b, int unsigned lg, logic [31:0] k,
                                    logic [31:0] h, output int unsigned where);
    int unsigned sz = 1 << lg;
    int unsigned z = h & (sz - 1);
    for (int unsigned n = 0; n < sz; n++) begin
      if (!tbl_used[b*1024+z]) begin where = z; return 0; end
      if (tbl_key[b*1024+z] == k) begin where = z; return 1; end
      z = (z + 1) & (sz - 1);
    end
    where = h & (sz - 1);
    return 2;
  endfunction

  function automatic int unsigned double_table(int unsigned track);
    int unsigned ob = bank, nb = bank ^ 1, res = 0, dst, src;
    for (int i = 0; i < 1024; i++) tbl_used[nb*1024+i] = 0;
    for (int unsigned s = 0; s < (1 << cap_log); s++) begin
      src = ob*1024 + s;
      if (!tbl_used[src]) continue;
      if (probe_slot(nb, cap_log+1, tbl_key[src], tbl_hash[src], dst) == 2) continue;
      tbl_used[nb*1024+dst] = 1;
      tbl_key[nb*1024+dst]  = tbl_key[src];
      tbl_hash[nb*1024+dst] = tbl_hash[src];
      tbl_val[nb*1024+dst]  = tbl_val[src];
      if (s == track) res = dst;
    end
    for (int i = 0; i < 1024; i++) tbl_used[ob*1024+i] = 0;
    bank = nb;
    cap_log++;
    return res;
  endfunction

  function automatic answer_t map_op(op_t op, logic [31:0] k, logic [31:0] h, logic [31:0] v);
    answer_t a = '0;
    int unsigned where = 0;
    int r;
    if (op == OP_PUT) begin
      r = probe_slot(bank, cap_log, k, h, where);
      if (r == 1) begin
        a.found = 1;
        tbl_val[bank*1024+where] = v;
      end else if (r == 0) begin
        tbl_used[bank*1024+where] = 1;
        tbl_key[bank*1024+where] = k;
        tbl_hash[bank*1024+where] = h;
        tbl_val[bank*1024+where] = v;
        n_entries++;
        if (n_entries*2 > (1 << cap_log) && cap_log < LARGEST_LOG) where = double_table(where);
      end else a.status = 1;
      a.slot = SLOT_W'(where);
    end else if (op == OP_GET) begin
      r = probe_slot(bank, cap_log, k, h, where);
      if (r == 1) begin a.found = 1; a.value_out = tbl_val[bank*1024+where]; end
      a.slot = SLOT_W'(where);
    end else if (op == OP_CLEAR) table_clear();
    a.entry_total = CNT_W'(n_entries);
    return a;
  endfunction

  // Result side: random stalls, a long hold when asked, and the checks.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 0;
    else begin
      if (out_ch.valid && out_ch.ready) begin
        answer_t w;
        if (answer_q.size() == 0) begin
          $error("result with nothing expected"); errors++;
        end else begin
          w = answer_q.pop_front();
          if (out_ch.found !== w.found) begin
            $error("found exp %0h got %0h", w.found, out_ch.found); errors++; end
          if (out_ch.value_out !== w.value_out) begin
            $error("value_out exp %0h got %0h", w.value_out, out_ch.value_out); errors++; end
          if (out_ch.slot !== w.slot) begin
            $error("slot exp %0d got %0d", w.slot, out_ch.slot); errors++; end
          if (out_ch.status !== w.status) begin
            $error("status exp %0h got %0h", w.status, out_ch.status); errors++; end
          if (out_ch.entry_total !== w.entry_total) begin
            $error("entry_total exp %0d got %0d", w.entry_total, out_ch.entry_total);
            errors++;
          end
        end
      end
      out_ch.ready <= !hold_out && ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) hold_out <= 0;
    else if (big_stall_req && !hold_out) hold_out <= 1;
  end

  initial begin
    wait (big_stall_req);
    @(posedge clk);
    repeat (300) @(posedge clk);
    hold_out <= 0;
    big_stall_req <= 0;
  end

  // Watchdog on accepted traffic.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("open_address_hash_map test failed");
      $finish;
    end
  end

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(op_t op, logic [31:0] k, logic [31:0] h, logic [31:0] v,
                              bit typed, answer_t want);
    answer_t a;
    in_ch.valid <= 1;
    in_ch.op <= op;
    in_ch.key <= k;
    in_ch.key_hash <= h;
    in_ch.new_value <= v;
    a = map_op(op, k, h, v);
    if (typed && a !== want) begin
      $error("table row exp %0h predictor %0h", want, a); errors++;
    end
    answer_q.push_back(a);
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 0;
    // The block stays busy after accepting a request, so the idle cycle here costs nothing.
    @(posedge clk);
  endtask

  task automatic drain();
    while (answer_q.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
  endtask

  task automatic write_capacity(logic [10:0] c);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.start_capacity <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    req_cap = c;
  endtask

  task automatic random_phase(int count, int unsigned key_span);
    logic [31:0] keys[$];
    logic [31:0] k, h;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (keys.size() == 0 || sel < 40) begin
        k = $urandom_range(0, key_span);
        if ($urandom_range(0, 7) == 0) k = $urandom;
        keys.push_back(k);
      end else k = keys[$urandom_range(0, keys.size()-1)];
      // Hash is a fixed function of the key so that re-puts find their entry.
      h = (k * 32'h9e3779b1) ^ {k[15:0], k[31:16]};
      if (sel < 55) send_request(OP_PUT, k, h, $urandom, 0, '0);
      else if (sel < 97) send_request(OP_GET, k, h, $urandom, 0, '0);
      else if (sel < 99) begin
        send_request(OP_CLEAR, $urandom, $urandom, $urandom, 0, '0);
        keys.delete();
      end else send_request(OP_NONE, $urandom, $urandom, $urandom, 0, '0);
      random_gap();
    end
  endtask

  stim_row_t rows[$];

  function automatic stim_row_t mk(op_t op, logic [31:0] k, logic [31:0] h, logic [31:0] v,
                                   bit typed, answer_t want);
    stim_row_t r;
    r.op = op; r.key = k; r.key_hash = h; r.new_value = v; r.typed = typed; r.want = want;
    return r;
  endfunction

  initial begin
    in_ch.valid = 0; in_ch.op = OP_PUT; in_ch.key = 0; in_ch.key_hash = 0;
    in_ch.new_value = 0; cfg_ch.valid = 0; cfg_ch.start_capacity = 0;
    req_cap = 8;
    foreach (tbl_key[i]) begin tbl_key[i] = 0; tbl_hash[i] = 0; tbl_val[i] = 0; end
    table_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // found, value, slot, status, total
    rows.push_back(mk(OP_GET, 32'h0, 32'h0, 32'h0, 1, '{0, 0, 0, 0, 0}));
    rows.push_back(mk(OP_PUT, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1,
                      '{0, 0, 7, 0, 1}));
    rows.push_back(mk(OP_GET, 32'hffffffff, 32'hffffffff, 0, 1,
                      '{1, 32'hffffffff, 7, 0, 1}));
    rows.push_back(mk(OP_PUT, 32'hffffffff, 32'hffffffff, 32'h0, 1, '{1, 0, 7, 0, 1}));
    rows.push_back(mk(OP_PUT, 32'h0, 32'h7, 32'h55, 0, '0));  // collides, wraps to slot 0
    rows.push_back(mk(OP_PUT, 32'h1, 32'h7, 32'haa, 0, '0));
    rows.push_back(mk(OP_PUT, 32'h2, 32'h7, 32'h1, 0, '0));
    rows.push_back(mk(OP_PUT, 32'h3, 32'h7, 32'h2, 0, '0));   // crosses half, grows
    rows.push_back(mk(OP_GET, 32'h1, 32'h7, 0, 0, '0));
    rows.push_back(mk(OP_GET, 32'h99, 32'h7, 0, 0, '0));
    rows.push_back(mk(OP_NONE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1,
                      '{0, 0, 0, 0, 5}));
    rows.push_back(mk(OP_CLEAR, 32'h5, 32'h5, 32'h5, 1, '{0, 0, 0, 0, 0}));
    rows.push_back(mk(OP_GET, 32'h3, 32'h7, 0, 1, '{0, 0, 7, 0, 0}));
    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].key, rows[i].key_hash, rows[i].new_value,
                   rows[i].typed, rows[i].want);
      random_gap();
    end

    // Smallest capacity: four slots, fill past half and grow through several sizes.
    write_capacity(11'd1);
    send_request(OP_CLEAR, 0, 0, 0, 0, '0);
    random_phase(150, 60);

    // Block fills while the result side is held off.
    big_stall_req = 1;
    random_phase(40, 20);
    drain();

    // Large requests: 1024 and 11'h7ff, both held at 1024 slots, then the odd size 37 and 8, dense traffic.
    write_capacity(11'd1024);
    send_request(OP_CLEAR, 0, 0, 0, 0, '0);
    random_phase(200, 700);
    write_capacity(11'h7ff);
    send_request(OP_CLEAR, 0, 0, 0, 0, '0);
    random_phase(50, 300);
    write_capacity(11'd37);
    send_request(OP_CLEAR, 0, 0, 0, 0, '0);
    random_phase(220, 900);
    write_capacity(11'd8);
    send_request(OP_CLEAR, 0, 0, 0, 0, '0);
    random_phase(140, 100);

    drain();
    if (errors == 0) $display("open_address_hash_map test passed");
    else $display("open_address_hash_map test failed");
    $finish;
  end
endmodule

[sim.f]
sv/ohm_pkg.sv
sv/ohm_in_if.sv
sv/ohm_out_if.sv
sv/ohm_cfg_if.sv
sv/ohm_mem.sv
sv/ohm_probe_unit.sv
sv/open_address_hash_map.sv
dv/open_address_hash_map_tb.sv
